@@ src/ili_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ili_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int POS_W      = 6;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_ROTATE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t               mode;
        logic [CMP_W-1:0]         pos;
        logic [CMP_W-1:0]         len;
        logic [CMP_W-1:0]         last_idx;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ src/ili_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ili_in_if;

    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [ili_pkg::POS_W-1:0]           position;
    logic signed [ili_pkg::DATA_W-1:0]   item_value;

    modport source (output valid, output action, output position, output item_value,
                    input ready);
    modport sink   (input valid, input action, input position, input item_value,
                    output ready);

endinterface

`default_nettype wire

@@ src/ili_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ili_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [ili_pkg::DATA_W-1:0]   entry_value;
    logic [ili_pkg::STATUS_W-1:0]        status;
    logic                                last_entry;

    modport source (output valid, output entry_value, output status, output last_entry,
                    input ready);
    modport sink   (input valid, input entry_value, input status, input last_entry,
                    output ready);

endinterface

`default_nettype wire

@@ src/ili_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ili_cell (
    input  wire logic                               clk,
    input  wire logic [ili_pkg::CMP_W-1:0]          idx,
    input  wire ili_pkg::cell_cmd_t                 cmd,
    input  wire logic signed [ili_pkg::DATA_W-1:0]  prev_value,
    input  wire logic signed [ili_pkg::DATA_W-1:0]  next_value,
    input  wire logic signed [ili_pkg::DATA_W-1:0]  head_value,
    output      logic signed [ili_pkg::DATA_W-1:0]  value
);

    logic signed [ili_pkg::DATA_W-1:0] value_reg;
    logic signed [ili_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.mode)
            ili_pkg::CELL_APPEND:
            begin
                if (idx == cmd.len)
                begin
                    value_next = cmd.value;
                end
            end
            ili_pkg::CELL_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    value_next = cmd.value;
                end
                else if ((idx > cmd.pos) && (idx <= cmd.len))
                begin
                    value_next = prev_value;
                end
            end
            ili_pkg::CELL_ROTATE:
            begin
                if (idx == cmd.last_idx)
                begin
                    value_next = head_value;
                end
                else if (idx < cmd.last_idx)
                begin
                    value_next = next_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ src/indexed_list_insert.sv @@
// Ordered list of up to 32 signed 32-bit values held in a row of cells, one
// entry per cell with the head in the first cell. A load transfer appends its
// value and produces no result; a load into a full list is dropped. An insert
// transfer moves the later entries back one cell and writes the new value in
// the same cycle, then the list is read out from the head by rotating the row
// one cell per cycle while the output register is free; an insert with a bad
// position or into a full list returns a single status result. A new input
// transfer is taken once the listing has been handed to the output register
// and the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ili_in_if.sink      items,
    ili_out_if.source   results
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [ili_pkg::LEN_W-1:0]            len_reg;
    logic [ili_pkg::LEN_W-1:0]            len_next;
    logic [ili_pkg::IDX_W-1:0]            cnt_reg;
    logic [ili_pkg::IDX_W-1:0]            cnt_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [ili_pkg::DATA_W-1:0]    out_value_reg;
    logic signed [ili_pkg::DATA_W-1:0]    out_value_next;
    logic [ili_pkg::STATUS_W-1:0]         out_status_reg;
    logic [ili_pkg::STATUS_W-1:0]         out_status_next;
    logic                                 out_last_reg;
    logic                                 out_last_next;

    ili_pkg::cell_cmd_t                   cmd;
    logic signed [ili_pkg::DATA_W-1:0]    cell_value [ili_pkg::LIST_DEPTH];
    logic                                 out_free;
    logic                                 in_fire;
    logic [ili_pkg::CMP_W-1:0]            len_ext;
    logic [ili_pkg::CMP_W-1:0]            pos_ext;
    logic [ili_pkg::CMP_W-1:0]            last_idx;
    logic                                 list_full;
    logic                                 final_entry;

    assign out_free    = !out_valid_reg || results.ready;
    assign items.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire     = items.valid && items.ready;
    assign len_ext     = ili_pkg::CMP_W'(len_reg);
    assign pos_ext     = ili_pkg::CMP_W'(items.position);
    assign last_idx    = ili_pkg::CMP_W'(len_reg - ili_pkg::LEN_W'(1));
    assign list_full   = (len_reg == ili_pkg::LEN_W'(ili_pkg::LIST_DEPTH));
    assign final_entry = (ili_pkg::CMP_W'(cnt_reg) == last_idx);

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        cmd.mode        = ili_pkg::CELL_HOLD;
        cmd.pos         = pos_ext;
        cmd.len         = len_ext;
        cmd.last_idx    = last_idx;
        cmd.value       = items.item_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (items.action == ili_pkg::ACT_LOAD)
                    begin
                        if (!list_full)
                        begin
                            cmd.mode = ili_pkg::CELL_APPEND;
                            len_next = len_reg + ili_pkg::LEN_W'(1);
                        end
                    end
                    else if (pos_ext > len_ext)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = ili_pkg::STATUS_INVALID;
                        out_last_next   = 1'b1;
                    end
                    else if (list_full)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = ili_pkg::STATUS_FULL;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.mode   = ili_pkg::CELL_INSERT;
                        len_next   = len_reg + ili_pkg::LEN_W'(1);
                        cnt_next   = '0;
                        state_next = ST_LIST;
                    end
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    cmd.mode        = ili_pkg::CELL_ROTATE;
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_value[0];
                    out_status_next = ili_pkg::STATUS_OK;
                    out_last_next   = final_entry;
                    cnt_next        = cnt_reg + ili_pkg::IDX_W'(1);
                    if (final_entry)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar k = 0; k < ili_pkg::LIST_DEPTH; k++)
    begin : g_cell
        ili_cell u_cell (
            .clk        (clk),
            .idx        (ili_pkg::CMP_W'(k)),
            .cmd        (cmd),
            .prev_value ((k == 0) ? items.item_value : cell_value[(k + ili_pkg::LIST_DEPTH - 1)
                                                               % ili_pkg::LIST_DEPTH]),
            .next_value (cell_value[(k + 1) % ili_pkg::LIST_DEPTH]),
            .head_value (cell_value[0]),
            .value      (cell_value[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.entry_value = out_value_reg;
    assign results.status      = out_status_reg;
    assign results.last_entry  = out_last_reg;

endmodule

`default_nettype wire

@@ sim/indexed_list_insert_tb.sv @@
`timescale 1ns / 1ps

module indexed_list_insert_tb;

    import ili_pkg::*;

    localparam int ITEM_TARGET = 270;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH
    } phase_t;

    typedef struct {
        logic                     action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
        phase_t                   phase;
        bit                       drain;
        bit                       hold_rx;
    } list_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] entry_value;
        logic [STATUS_W-1:0]      status;
        logic                     last_entry;
    } list_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    ili_in_if  item_ch ();
    ili_out_if result_ch ();

    indexed_list_insert u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    list_item_t  item_q [$];
    list_entry_t entries_due [$];
    list_item_t  offered;
    list_entry_t want;

    logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
    int list_len = 0;

    phase_t cur_phase = PH_FREE;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_left = 0;
    int     mismatches = 0;
    int     stall_cycles = 0;

    int gen_len = 0;
    int counted = 0;
    int free_run = 0;
    int r;
    bit drain_placed = 1'b0;
    bit hold_placed = 1'b0;
    bit drain_now;
    bit hold_now;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_pct(input phase_t ph, input bit sender);
        case (ph)
            PH_TX_IDLE:  return sender ? 50 : 0;
            PH_RX_STALL: return sender ? 0 : 50;
            PH_BOTH:     return 17;
            default:     return 0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic act, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val,
                            input bit drain, input bit hold);
        list_item_t it;
        if (hold)
            free_run = 10;
        it.action = act;
        it.position = pos;
        it.item_value = val;
        it.phase = (free_run > 0) ? PH_FREE : phase_t'((item_q.size() / 12) % 4);
        it.drain = drain;
        it.hold_rx = hold;
        if (free_run > 0)
            free_run--;
        item_q.push_back(it);
        counted++;
        if (gen_len < LIST_DEPTH && (act == ACT_LOAD || int'(pos) <= gen_len))
            gen_len++;
    endtask

    task automatic insert_and_list(input list_item_t it);
        int k;
        list_entry_t e;
        if (it.action == ACT_LOAD)
        begin
            if (list_len < LIST_DEPTH)
            begin
                list_mem[list_len] = it.item_value;
                list_len++;
            end
        end
        else if (int'(it.position) > list_len || list_len >= LIST_DEPTH)
        begin
            e.entry_value = '0;
            e.status = (int'(it.position) > list_len) ? STATUS_INVALID : STATUS_FULL;
            e.last_entry = 1'b1;
            entries_due.push_back(e);
        end
        else
        begin
            for (k = list_len; k > int'(it.position); k--)
                list_mem[k] = list_mem[k-1];
            list_mem[it.position] = it.item_value;
            list_len++;
            for (k = 0; k < list_len; k++)
            begin
                e.entry_value = list_mem[k];
                e.status = STATUS_OK;
                e.last_entry = (k == list_len - 1);
                entries_due.push_back(e);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                insert_and_list(offered);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_q.size() != 0
                    && !(item_q[0].drain && entries_due.size() != 0)
                    && $urandom_range(99) >= idle_pct(item_q[0].phase, 1'b1))
                begin
                    offered = item_q.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.action <= offered.action;
                    item_ch.position <= offered.position;
                    item_ch.item_value <= offered.item_value;
                    cur_phase <= offered.phase;
                    if (offered.hold_rx)
                        hold_req <= 1'b1;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (entries_due.size() == 0)
                begin
                    $display("%0t: unexpected result: value %0d status %0d last %0b",
                             $time, result_ch.entry_value, result_ch.status,
                             result_ch.last_entry);
                    mismatches++;
                end
                else
                begin
                    want = entries_due.pop_front();
                    if (result_ch.entry_value !== want.entry_value
                        || result_ch.status !== want.status
                        || result_ch.last_entry !== want.last_entry)
                    begin
                        $display("%0t: expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
                                 $time, want.entry_value, want.status, want.last_entry,
                                 result_ch.entry_value, result_ch.status,
                                 result_ch.last_entry);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b0));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("indexed_list_insert_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD;
        item_ch.position = '0;
        item_ch.item_value = '0;
        result_ch.ready = 1'b0;
        rst_n = 1'b0;

        add_item(ACT_INSERT, 6'd1, 32'sd5, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd63, -32'sd5, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd0, {1'b1, {(DATA_W-1){1'b0}}}, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd0, {1'b0, {(DATA_W-1){1'b1}}}, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd2, -32'sd1, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd1, 32'sd0, 1'b0, 1'b0);
        add_item(ACT_LOAD, 6'd0, 32'sd1, 1'b0, 1'b0);
        add_item(ACT_LOAD, 6'd63, 32'h5555_5555, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd7, 32'sd9, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd6, 32'haaaa_aaaa, 1'b0, 1'b0);

        while (gen_len < LIST_DEPTH)
        begin
            drain_now = (gen_len >= 10 && !drain_placed);
            hold_now = (gen_len >= 20 && !hold_placed);
            drain_placed |= drain_now;
            hold_placed |= hold_now;
            r = $urandom_range(99);
            if (r < 20)
                add_item(ACT_LOAD, POS_W'($urandom), rand_value(), drain_now, hold_now);
            else if (r < 30)
                add_item(ACT_INSERT, POS_W'($urandom_range(63, gen_len + 1)), rand_value(),
                         drain_now, hold_now);
            else
                add_item(ACT_INSERT, POS_W'($urandom_range(gen_len, 0)), rand_value(),
                         drain_now, hold_now);
        end

        add_item(ACT_LOAD, 6'd0, 32'sd77, 1'b1, 1'b0);
        add_item(ACT_INSERT, 6'd0, 32'sd1, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd32, 32'sd2, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd33, 32'sd3, 1'b0, 1'b0);
        add_item(ACT_INSERT, 6'd63, 32'sd4, 1'b0, 1'b0);

        drain_placed = 1'b0;
        while (counted < ITEM_TARGET)
        begin
            drain_now = (counted >= 200 && !drain_placed);
            drain_placed |= drain_now;
            if ($urandom_range(99) < 25)
                add_item(ACT_LOAD, POS_W'($urandom), rand_value(), drain_now, 1'b0);
            else
                add_item(ACT_INSERT, POS_W'($urandom_range(63, 0)), rand_value(),
                         drain_now, 1'b0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (item_q.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (entries_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && entries_due.size() == 0)
        begin
            $display("indexed_list_insert_tb OK");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d results missing", $time, mismatches,
                     entries_due.size());
            $display("indexed_list_insert_tb NOT OK");
        end
        $finish;
    end

endmodule
